>>> sv/sm4_pkg.sv
`timescale 1ns / 1ps

package sm4_pkg;

    // Round count and round-key memory geometry
    localparam int ROUNDS  = 32;
    localparam int RK_W    = 32;
    localparam int RK_AW   = $clog2(ROUNDS);
    localparam int CFG_IW  = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_KEY_HIGH = 3'd0,
        CFG_KEY_LOW  = 3'd1,
        CFG_IV_HIGH  = 3'd2,
        CFG_IV_LOW   = 3'd3,
        CFG_DECRYPT  = 3'd4,
        CFG_CHAINING = 3'd5
    } t_cfg_idx;

    // Controller states
    typedef enum logic [2:0] {
        ST_KEY_LOAD,
        ST_KEY_RUN,
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic             key_load;
        logic             key_round;
        logic             blk_load;
        logic             blk_round;
        logic             fin;
        logic [RK_AW-1:0] cnt;
        logic [RK_AW-1:0] rk_base;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic key_wr;
    } t_sts;

    localparam logic [31:0] FK [4] = '{
        32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
    };

    localparam logic [31:0] CK [ROUNDS] = '{
        32'h00070E15, 32'h1C232A31, 32'h383F464D, 32'h545B6269,
        32'h70777E85, 32'h8C939AA1, 32'hA8AFB6BD, 32'hC4CBD2D9,
        32'hE0E7EEF5, 32'hFC030A11, 32'h181F262D, 32'h343B4249,
        32'h50575E65, 32'h6C737A81, 32'h888F969D, 32'hA4ABB2B9,
        32'hC0C7CED5, 32'hDCE3EAF1, 32'hF8FF060D, 32'h141B2229,
        32'h30373E45, 32'h4C535A61, 32'h686F767D, 32'h848B9299,
        32'hA0A7AEB5, 32'hBCC3CAD1, 32'hD8DFE6ED, 32'hF4FB0209,
        32'h10171E25, 32'h2C333A41, 32'h484F565D, 32'h646B7279
    };

    localparam logic [7:0] SBOX [256] = '{
        8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
        8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
        8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
        8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
        8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
        8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
        8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
        8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
        8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
        8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
        8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
        8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
        8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
        8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
        8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
    };

    // Byte-wise S-box on a 32-bit word
    function automatic logic [31:0] sm4_sub(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

>>> sv/sm4_ram.sv
`timescale 1ns / 1ps

module sm4_ram #(
    parameter int W = 32,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/sm4_ctrl.sv
`timescale 1ns / 1ps

module sm4_ctrl
    import sm4_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic [RK_AW-1:0] LAST = RK_AW'(ROUNDS - 1);

    t_state           r_state, n_state;
    logic [RK_AW-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             in_acc;
    logic             out_free;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_KEY_LOAD: n_state = ST_KEY_RUN;
            ST_KEY_RUN: begin
                if (r_cnt == LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_cnt == LAST) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_KEY_LOAD;
        endcase
        // a new key restarts the expansion
        if (i_sts.key_wr) n_state = ST_KEY_LOAD;
    end

    // Outputs and commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.cnt       = r_cnt;
        o_cmd.key_load  = (r_state == ST_KEY_LOAD);
        o_cmd.key_round = (r_state == ST_KEY_RUN);
        o_cmd.blk_load  = in_acc;
        o_cmd.blk_round = (r_state == ST_RUN);
        o_cmd.fin       = (r_state == ST_FIN) && out_free;
        // key for the next round is fetched in the cycle before its round
        o_cmd.rk_base   = (r_state == ST_RUN) ? r_cnt + 1'b1 : '0;

        n_cnt = ((r_state == ST_KEY_RUN) || (r_state == ST_RUN)) ? r_cnt + 1'b1 : '0;

        n_out_valid = o_cmd.fin || (r_out_valid && i_out_stall);
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_KEY_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> sv/sm4_dp.sv
`timescale 1ns / 1ps

module sm4_dp
    import sm4_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic [63:0]       i_data_high,
    input  logic [63:0]       i_data_low,
    input  logic              i_first_block,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic [63:0]       o_result_high,
    output logic [63:0]       o_result_low
);

    logic [63:0]           r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic                  r_decrypt, r_chaining;
    logic [127:0]          r_chain, r_din, r_out;
    logic [0:3][31:0]      r_x;
    logic [RK_W-1:0]       rk_rdata;
    logic [RK_AW-1:0]      rk_raddr;
    logic [31:0]           rc, t, b, lin, nw;
    logic [127:0]          cv, blk, res, outv;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
            r_decrypt  <= 1'b0;
            r_chaining <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                CFG_DECRYPT:  r_decrypt  <= i_cfg_data[0];
                CFG_CHAINING: r_chaining <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_sts.key_wr = i_cfg_valid &&
        ((t_cfg_idx'(i_cfg_index) == CFG_KEY_HIGH) || (t_cfg_idx'(i_cfg_index) == CFG_KEY_LOW));

    // Round keys: written during expansion, read reversed when decrypting
    assign rk_raddr = i_cmd.rk_base ^ {RK_AW{r_decrypt}};

    sm4_ram #(
        .W (RK_W),
        .D (ROUNDS)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.key_round),
        .i_waddr (i_cmd.cnt),
        .i_wdata (nw),
        .i_raddr (rk_raddr),
        .o_rdata (rk_rdata)
    );

    // Shared round function: L' for key expansion, L for the cipher
    always_comb begin
        rc  = i_cmd.key_round ? CK[i_cmd.cnt] : rk_rdata;
        t   = r_x[1] ^ r_x[2] ^ r_x[3] ^ rc;
        b   = sm4_sub(t);
        if (i_cmd.key_round) begin
            lin = b ^ rol32(b, 13) ^ rol32(b, 23);
        end else begin
            lin = b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
        end
        nw  = r_x[0] ^ lin;
    end

    // Block entry and exit with CBC chaining
    always_comb begin
        cv   = i_first_block ? {r_iv_high, r_iv_low} : r_chain;
        blk  = {i_data_high, i_data_low};
        res  = {r_x[3], r_x[2], r_x[1], r_x[0]};
        outv = (r_chaining && r_decrypt) ? (res ^ r_chain) : res;
    end

    // Working words
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            r_x <= {r_key_high[63:32] ^ FK[0], r_key_high[31:0] ^ FK[1],
                    r_key_low[63:32] ^ FK[2], r_key_low[31:0] ^ FK[3]};
        end else if (i_cmd.blk_load) begin
            r_x <= (r_chaining && !r_decrypt) ? (blk ^ cv) : blk;
        end else if (i_cmd.key_round || i_cmd.blk_round) begin
            r_x <= {r_x[1], r_x[2], r_x[3], nw};
        end
    end

    // Held input block and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_load) begin
            r_din <= blk;
        end
        if (i_cmd.fin) begin
            r_out <= outv;
        end
    end

    // Chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (i_cmd.blk_load) begin
            r_chain <= cv;
        end else if (i_cmd.fin && r_chaining) begin
            r_chain <= r_decrypt ? r_din : outv;
        end
    end

    assign o_result_high = r_out[127:64];
    assign o_result_low  = r_out[63:0];

endmodule

>>> sv/sm4_block_cipher_ecb_cbc_top.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_stall    i_data_high, i_data_low, i_first_block
// output    o_out_valid / i_out_stall  o_result_high, o_result_low
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word passes through accept, 32 rounds of the shared round unit and result load.
// A key write re-expands the round keys; no input word is taken meanwhile.
// Reset runs the same expansion for the all-zero key before the first word.
// A result waits in the output register while stalled; the next word may be accepted.

module sm4_block_cipher_ecb_cbc_top
    import sm4_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [63:0]       i_data_high,
    input  logic [63:0]       i_data_low,
    input  logic              i_first_block,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [63:0]       o_result_high,
    output logic [63:0]       o_result_low,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [63:0]       i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sm4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    sm4_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_data_high   (i_data_high),
        .i_data_low    (i_data_low),
        .i_first_block (i_first_block),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_result_high (o_result_high),
        .o_result_low  (o_result_low)
    );

endmodule
